// ===== rtl/rsms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the repeated string move sequencer.
// No dependencies; used by every rtl file of the block.
package rsms_pkg;

   localparam int DATA_W  = 64;
   localparam int CAP_W   = 7;
   localparam int BYTES_W = 4;

   localparam logic [CAP_W-1:0] MAX_RUN   = 7'd64;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
   localparam logic [CAP_W-1:0] CAP_MIN   = 7'd1;

   // address size codes
   localparam logic [1:0] ASZ_16 = 2'd0;
   localparam logic [1:0] ASZ_32 = 2'd1;

   localparam logic [DATA_W-1:0] MASK_ALL = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] MASK_16  = 64'h0000_0000_0000_FFFF;
   localparam logic [DATA_W-1:0] MASK_32  = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [DATA_W-1:0] count_in;
      logic [DATA_W-1:0] src_index;
      logic [DATA_W-1:0] dst_index;
      logic [DATA_W-1:0] src_seg_base;
      logic [1:0]        width_code;
      logic              direction_down;
      logic              repeat_prefix;
      logic [1:0]        addr_size;
      logic              trap_flag;
   } req_type;

   typedef struct packed {
      logic               move_valid;
      logic [DATA_W-1:0]  read_address;
      logic [DATA_W-1:0]  write_address;
      logic [BYTES_W-1:0] access_bytes;
      logic [DATA_W-1:0]  count_out;
      logic [DATA_W-1:0]  src_out;
      logic [DATA_W-1:0]  dst_out;
      logic               yielded;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic              sub;
      logic [DATA_W-1:0] mask;
   } alu_op_type;

   function automatic logic [DATA_W-1:0] asz_to_mask(input logic [1:0] asz);
      logic [DATA_W-1:0] m;
      begin
         unique case (asz)
            ASZ_16:  m = MASK_16;
            ASZ_32:  m = MASK_32;
            default: m = MASK_ALL;
         endcase
         return m;
      end
   endfunction

   function automatic logic [BYTES_W-1:0] bytes_of(input logic [1:0] width_code);
      logic [BYTES_W-1:0] b;
      begin
         b = BYTES_W'(1) << width_code;
         return b;
      end
   endfunction

endpackage

// ===== rtl/rsms_alu.sv =====
`timescale 1ns / 1ps
// Shared 64-bit add/subtract unit with an output mask.
// Depends on rsms_pkg.
module rsms_alu (
   input  logic [rsms_pkg::DATA_W-1:0] opa,
   input  logic [rsms_pkg::DATA_W-1:0] opb,
   input  rsms_pkg::alu_op_type        op,
   output logic [rsms_pkg::DATA_W-1:0] result
);

   logic [rsms_pkg::DATA_W-1:0] raw;

   always_comb begin
      if (op.sub) begin
         raw = opa - opb;
      end else begin
         raw = opa + opb;
      end
      result = raw & op.mask;
   end

endmodule

// ===== rtl/rsms_sequencer.sv =====
`timescale 1ns / 1ps
// Move sequencer: latches one instruction start and walks its moves through the shared adder.
// Depends on rsms_pkg and rsms_alu.
module rsms_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rsms_pkg::req_type             req_data,
   input  logic [rsms_pkg::CAP_W-1:0]    cap_reg,
   input  logic                          out_free,
   output logic                          out_load,
   output rsms_pkg::rsp_type             out_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_SRC,
      S_DST,
      S_CNT,
      S_EMIT,
      S_ZERO
   } state_type;

   state_type                     state_ff, state_in;
   logic [rsms_pkg::CAP_W-1:0]    iter_ff, iter_in;
   logic [rsms_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic [rsms_pkg::DATA_W-1:0]   cnt_ff, cnt_in;
   logic [rsms_pkg::DATA_W-1:0]   cin_ff, cin_in;
   logic [rsms_pkg::DATA_W-1:0]   si_ff, si_in;
   logic [rsms_pkg::DATA_W-1:0]   di_ff, di_in;
   logic [rsms_pkg::DATA_W-1:0]   base_ff, base_in;
   logic [rsms_pkg::DATA_W-1:0]   rd_ff, rd_in;
   logic [rsms_pkg::DATA_W-1:0]   wr_ff, wr_in;
   logic [rsms_pkg::BYTES_W-1:0]  bytes_ff, bytes_in;
   logic                          down_ff, down_in;
   logic                          rep_ff, rep_in;
   logic [1:0]                    asz_ff, asz_in;

   logic [rsms_pkg::DATA_W-1:0]   alu_a, alu_b, alu_y;
   rsms_pkg::alu_op_type          alu_op;
   logic [rsms_pkg::DATA_W-1:0]   in_mask;
   logic [rsms_pkg::DATA_W-1:0]   in_count;
   logic                          in_zero;
   logic [rsms_pkg::CAP_W-1:0]    cap_eff;
   logic [rsms_pkg::CAP_W-1:0]    iter_next;
   logic                          cnt_done;
   logic                          cap_hit;

   rsms_alu u_alu (
      .opa    (alu_a),
      .opb    (alu_b),
      .op     (alu_op),
      .result (alu_y)
   );

   // operand select for the shared adder
   always_comb begin
      alu_a       = si_ff;
      alu_b       = base_ff;
      alu_op.sub  = 1'b0;
      alu_op.mask = rsms_pkg::MASK_ALL;
      unique case (state_ff)
         S_SRC: begin
            alu_b       = {{(rsms_pkg::DATA_W-rsms_pkg::BYTES_W){1'b0}}, bytes_ff};
            alu_op.sub  = down_ff;
            alu_op.mask = rsms_pkg::asz_to_mask(asz_ff);
         end
         S_DST: begin
            alu_a       = di_ff;
            alu_b       = {{(rsms_pkg::DATA_W-rsms_pkg::BYTES_W){1'b0}}, bytes_ff};
            alu_op.sub  = down_ff;
            alu_op.mask = rsms_pkg::asz_to_mask(asz_ff);
         end
         S_CNT: begin
            alu_a      = cnt_ff;
            alu_b      = rsms_pkg::DATA_W'(1);
            alu_op.sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      in_mask  = rsms_pkg::asz_to_mask(req_data.addr_size);
      in_count = req_data.count_in & in_mask;
      in_zero  = req_data.repeat_prefix && (in_count == '0);

      priority if (req_data.trap_flag) begin
         cap_eff = rsms_pkg::CAP_MIN;
      end else if (cap_reg == '0) begin
         cap_eff = rsms_pkg::CAP_MIN;
      end else if (cap_reg > rsms_pkg::MAX_RUN) begin
         cap_eff = rsms_pkg::MAX_RUN;
      end else begin
         cap_eff = cap_reg;
      end

      iter_next = iter_ff + rsms_pkg::CAP_W'(1);
      cnt_done  = (cnt_ff == '0);
      cap_hit   = (iter_next >= cap_ff);
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cap_in   = cap_ff;
      cnt_in   = cnt_ff;
      cin_in   = cin_ff;
      si_in    = si_ff;
      di_in    = di_ff;
      base_in  = base_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      bytes_in = bytes_ff;
      down_in  = down_ff;
      rep_in   = rep_ff;
      asz_in   = asz_ff;
      out_load = 1'b0;

      out_data.move_valid    = 1'b1;
      out_data.read_address  = rd_ff;
      out_data.write_address = wr_ff;
      out_data.access_bytes  = bytes_ff;
      out_data.count_out     = rep_ff ? cnt_ff : cin_ff;
      out_data.src_out       = si_ff;
      out_data.dst_out       = di_ff;
      out_data.yielded       = !cnt_done && cap_hit;
      out_data.last          = cnt_done || cap_hit;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               iter_in  = '0;
               cap_in   = cap_eff;
               cin_in   = req_data.count_in;
               cnt_in   = req_data.repeat_prefix ? in_count : rsms_pkg::DATA_W'(1);
               // a zero-count start reports the raw indices untouched
               si_in    = in_zero ? req_data.src_index : (req_data.src_index & in_mask);
               di_in    = in_zero ? req_data.dst_index : (req_data.dst_index & in_mask);
               base_in  = req_data.src_seg_base;
               bytes_in = rsms_pkg::bytes_of(req_data.width_code);
               down_in  = req_data.direction_down;
               rep_in   = req_data.repeat_prefix;
               asz_in   = req_data.addr_size;
               state_in = in_zero ? S_ZERO : S_RD;
            end
         end
         S_RD: begin
            rd_in    = alu_y;
            state_in = S_SRC;
         end
         S_SRC: begin
            si_in    = alu_y;
            state_in = S_DST;
         end
         S_DST: begin
            wr_in    = di_ff;
            di_in    = alu_y;
            state_in = S_CNT;
         end
         S_CNT: begin
            // without a prefix cnt starts at one, so this marks the single move as done
            cnt_in   = alu_y;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               iter_in  = iter_next;
               state_in = (cnt_done || cap_hit) ? S_IDLE : S_RD;
            end
         end
         S_ZERO: begin
            out_data.move_valid    = 1'b0;
            out_data.read_address  = '0;
            out_data.write_address = '0;
            out_data.count_out     = cin_ff;
            out_data.yielded       = 1'b0;
            out_data.last          = 1'b1;
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         cap_ff   <= cap_in;
         cnt_ff   <= cnt_in;
         cin_ff   <= cin_in;
         si_ff    <= si_in;
         di_ff    <= di_in;
         base_ff  <= base_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         bytes_ff <= bytes_in;
         down_ff  <= down_in;
         rep_ff   <= rep_in;
         asz_ff   <= asz_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_iter_within_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_ZERO) |-> (iter_ff < cap_ff))
      else $error("move counter ran past the iteration cap");

   a_yield_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_data.yielded) |-> out_data.last)
      else $error("yield flagged on a non-final result");

   a_final_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_data.last) |=> (state_ff == S_IDLE))
      else $error("sequencer kept running after the final result");

   a_more_moves_follow: assert property (@(posedge clock) disable iff (reset)
      (out_load && !out_data.last) |=> (state_ff == S_RD))
      else $error("non-final result not followed by another move");

endmodule

// ===== rtl/rep_string_move_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the repeated string move sequencer: cap register and result register.
// Depends on rsms_pkg and rsms_sequencer.
//
// One request transfer starts a MOVS instruction; the block answers with one result per element
// move (or a single move_valid=0 result for a zero count), the last one flagged by last. Every
// move makes four passes through the one shared 64-bit adder (read address, source step,
// destination step, counter step) and then hands its result to the output register once that
// register is free; a start covers n moves, with n at most the iteration cap (64 after reset,
// 1 with the trap flag). req_stall stays high until the final result is in the output register;
// the next start can be taken while that result waits.
// csr_wr_en writes the cap, which should only change while no start is in flight.
module rep_string_move_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  rsms_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsms_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [rsms_pkg::CAP_W-1:0] csr_wr_data
);

   logic [rsms_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsms_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic                       out_free;
   logic                       out_load;
   rsms_pkg::rsp_type          out_data;

   rsms_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cap_reg   (cap_ff),
      .out_free  (out_free),
      .out_load  (out_load),
      .out_data  (out_data)
   );

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= rsms_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/tb_rep_string_move_sequencer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rep_string_move_sequencer: directed table, then random MOVS starts.
// Depends on rsms_pkg and the block's rtl; expected moves come from a local predictor or the table.
module tb_rep_string_move_sequencer;

   localparam int STALL_LIMIT  = 5000;
   localparam int ITEMS_PHASE  = 34;
   localparam int NUM_PHASES   = 6;

   typedef struct {
      rsms_pkg::req_type req;
      bit                typed;
      rsms_pkg::rsp_type exp;
   } dir_row_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   rsms_pkg::req_type          req_data    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   rsms_pkg::rsp_type          rsp_data;
   logic                       csr_wr_en   = 1'b0;
   logic [rsms_pkg::CAP_W-1:0] csr_wr_data = '0;

   rsms_pkg::rsp_type          pending_moves[$];
   dir_row_type                dir_rows[$];
   logic [rsms_pkg::CAP_W-1:0] cap_setting   = rsms_pkg::CAP_RESET;
   int                         send_idle_pct = 7;
   int                         recv_stall_pct = 83;
   int                         errors = 0;
   int                         quiet_cycles = 0;

   rep_string_move_sequencer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] mask_for(input logic [1:0] asz);
      case (asz)
         rsms_pkg::ASZ_16: return rsms_pkg::MASK_16;
         rsms_pkg::ASZ_32: return rsms_pkg::MASK_32;
         default:          return rsms_pkg::MASK_ALL;
      endcase
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic rsms_pkg::rsp_type make_move(input logic valid, input logic [63:0] rd,
                                         input logic [63:0] wr, input logic [3:0] nbytes,
                                         input logic [63:0] cnt, input logic [63:0] s,
                                         input logic [63:0] d, input logic y, input logic l);
      rsms_pkg::rsp_type m;
      m.move_valid    = valid;
      m.read_address  = rd;
      m.write_address = wr;
      m.access_bytes  = nbytes;
      m.count_out     = cnt;
      m.src_out       = s;
      m.dst_out       = d;
      m.yielded       = y;
      m.last          = l;
      return m;
   endfunction

   function automatic rsms_pkg::req_type mk_req(input logic [63:0] cnt, input logic [63:0] src,
                                      input logic [63:0] dst, input logic [63:0] base,
                                      input logic [1:0] wc, input logic down, input logic rep,
                                      input logic [1:0] asz, input logic trap);
      rsms_pkg::req_type r;
      r.count_in       = cnt;
      r.src_index      = src;
      r.dst_index      = dst;
      r.src_seg_base   = base;
      r.width_code     = wc;
      r.direction_down = down;
      r.repeat_prefix  = rep;
      r.addr_size      = asz;
      r.trap_flag      = trap;
      return r;
   endfunction

   // Expand one MOVS start into the moves the block must produce.
   function automatic void predict_moves(input rsms_pkg::req_type r);
      logic [63:0] mask, si, di, count, remaining, cnt, step;
      logic [3:0]  nbytes;
      int          cap;
      begin
         mask   = mask_for(r.addr_size);
         nbytes = 4'd1 << r.width_code;
         step   = 64'(nbytes);
         cap    = int'(cap_setting);
         if (cap == 0) cap = 1;
         if (cap > int'(rsms_pkg::MAX_RUN)) cap = int'(rsms_pkg::MAX_RUN);
         if (r.trap_flag) cap = 1;
         count = r.repeat_prefix ? (r.count_in & mask) : 64'd1;
         if (count == 64'd0) begin
            pending_moves.push_back(make_move(1'b0, '0, '0, nbytes, r.count_in,
                                              r.src_index, r.dst_index, 1'b0, 1'b1));
            return;
         end
         si = r.src_index & mask;
         di = r.dst_index & mask;
         for (int i = 0; i < cap; i++) begin
            logic [63:0] rd, wr;
            rd = si + r.src_seg_base;
            wr = di;
            si = (r.direction_down ? si - step : si + step) & mask;
            di = (r.direction_down ? di - step : di + step) & mask;
            remaining = count - 64'(i) - 64'd1;
            cnt = r.repeat_prefix ? remaining : r.count_in;
            if (remaining == 64'd0) begin
               pending_moves.push_back(make_move(1'b1, rd, wr, nbytes, cnt, si, di, 1'b0, 1'b1));
               break;
            end
            if (i + 1 >= cap) begin
               pending_moves.push_back(make_move(1'b1, rd, wr, nbytes, cnt, si, di, 1'b1, 1'b1));
               break;
            end
            pending_moves.push_back(make_move(1'b1, rd, wr, nbytes, cnt, si, di, 1'b0, 1'b0));
         end
      end
   endfunction

   // Index value sitting next to a wrap point of the address mask, random above it.
   function automatic logic [63:0] near_wrap(input logic [63:0] mask);
      logic [63:0] low;
      low = $urandom_range(0, 1) ? 64'($urandom_range(0, 15))
                                 : mask - 64'($urandom_range(0, 15));
      return (rand64() & ~mask) | (low & mask);
   endfunction

   function automatic rsms_pkg::req_type rand_req();
      rsms_pkg::req_type r;
      logic [63:0]       mask;
      int                pick;
      r.width_code     = 2'($urandom_range(0, 3));
      r.direction_down = 1'($urandom_range(0, 1));
      r.repeat_prefix  = ($urandom_range(0, 7) != 0);
      r.addr_size      = 2'($urandom_range(0, 3));
      r.trap_flag      = ($urandom_range(0, 7) == 0);
      mask = mask_for(r.addr_size);
      pick = $urandom_range(0, 9);
      if (pick < 6)
         r.count_in = (rand64() & ~mask) | 64'($urandom_range(1, 70));
      else if (pick < 9)
         r.count_in = rand64();
      else
         r.count_in = rand64() & ~mask;   // masked count of zero
      r.src_index    = ($urandom_range(0, 2) == 0) ? near_wrap(mask) : rand64();
      r.dst_index    = ($urandom_range(0, 2) == 0) ? near_wrap(mask) : rand64();
      r.src_seg_base = ($urandom_range(0, 5) == 0)
                       ? rsms_pkg::MASK_ALL - 64'($urandom_range(0, 7)) : rand64();
      return r;
   endfunction

   task automatic add_row(input rsms_pkg::req_type r, input bit typed,
                          input rsms_pkg::rsp_type e);
      dir_row_type row;
      row.req   = r;
      row.typed = typed;
      row.exp   = e;
      dir_rows.push_back(row);
   endtask

   // Called at a rising edge; returns at the edge where the transfer happens.
   task automatic send_req(input rsms_pkg::req_type r, input bit typed,
                           input rsms_pkg::rsp_type e);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (typed)
         pending_moves.push_back(e);
      else
         predict_moves(r);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_moves.size() != 0);
   endtask

   task automatic write_cap(input logic [rsms_pkg::CAP_W-1:0] v);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_setting = v;
   endtask

   task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] a);
      if (e !== a) begin
         $error("%s: expected %h, got %h", name, e, a);
         errors++;
      end
   endtask

   task automatic check_move(input rsms_pkg::rsp_type act);
      rsms_pkg::rsp_type e;
      if (pending_moves.size() == 0) begin
         $error("result transfer with no move pending: %p", act);
         errors++;
         return;
      end
      e = pending_moves.pop_front();
      cmp_field("move_valid",    64'(e.move_valid),   64'(act.move_valid));
      cmp_field("read_address",  e.read_address,      act.read_address);
      cmp_field("write_address", e.write_address,     act.write_address);
      cmp_field("access_bytes",  64'(e.access_bytes), 64'(act.access_bytes));
      cmp_field("count_out",     e.count_out,         act.count_out);
      cmp_field("src_out",       e.src_out,           act.src_out);
      cmp_field("dst_out",       e.dst_out,           act.dst_out);
      cmp_field("yielded",       64'(e.yielded),      64'(act.yielded));
      cmp_field("last",          64'(e.last),         64'(act.last));
   endtask

   // Result side: check transfers, randomize stall, watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            check_move(rsp_data);
            quiet_cycles = 0;
         end else if (req_valid === 1'b1 && req_stall === 1'b0) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_rep_string_move_sequencer NOT OK");
            $finish;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   initial begin
      logic [rsms_pkg::CAP_W-1:0] caps [NUM_PHASES];
      caps[0] = 7'd1;
      caps[1] = 7'd127;            // above the run limit, acts as 64
      caps[2] = 7'd0;              // acts as 1
      caps[3] = rsms_pkg::MAX_RUN;
      caps[4] = 7'($urandom_range(2, 63));
      caps[5] = 7'd65;

      // zero counts, including ones that only vanish under the mask
      add_row(mk_req('0, 64'h1234, 64'h5678, 64'hAAAA, 2'd3, 1'b0, 1'b1, 2'd2, 1'b0), 1'b1,
              make_move(1'b0, '0, '0, 4'd8, '0, 64'h1234, 64'h5678, 1'b0, 1'b1));
      add_row(mk_req(64'h1_0000, 64'hDEAD_BEEF_0001_2345, 64'h0123_4567_89AB_CDEF,
                     rsms_pkg::MASK_ALL, 2'd1, 1'b1, 1'b1, rsms_pkg::ASZ_16, 1'b0), 1'b1,
              make_move(1'b0, '0, '0, 4'd2, 64'h1_0000, 64'hDEAD_BEEF_0001_2345,
                        64'h0123_4567_89AB_CDEF, 1'b0, 1'b1));
      add_row(mk_req(64'h1_0000_0000, rsms_pkg::MASK_ALL, rsms_pkg::MASK_ALL, '0, 2'd2,
                     1'b0, 1'b1, rsms_pkg::ASZ_32, 1'b1), 1'b1,
              make_move(1'b0, '0, '0, 4'd4, 64'h1_0000_0000, rsms_pkg::MASK_ALL,
                        rsms_pkg::MASK_ALL, 1'b0, 1'b1));
      // no prefix: one move, counter untouched
      add_row(mk_req(rsms_pkg::MASK_ALL, 64'h10, 64'h20, 64'h1000, 2'd0, 1'b0, 1'b0, 2'd2,
                     1'b0), 0, '0);
      add_row(mk_req('0, '0, '0, '0, 2'd0, 1'b0, 1'b0, 2'd0, 1'b0), 0, '0);
      // index wrap under each mask, with both directions covered
      add_row(mk_req(64'd5, 64'hFFFE, 64'hFFFC, 64'h100, 2'd0, 1'b0, 1'b1, rsms_pkg::ASZ_16,
                     1'b0), 0, '0);
      add_row(mk_req(64'd5, 64'h2, 64'h1_0001, '0, 2'd1, 1'b1, 1'b1, rsms_pkg::ASZ_16, 1'b0),
              0, '0);
      add_row(mk_req(64'd3, 64'hFFFF_FFFC, 64'h8, '0, 2'd2, 1'b0, 1'b1, rsms_pkg::ASZ_32,
                     1'b0), 0, '0);
      add_row(mk_req(64'd4, '0, 64'h8, '0, 2'd3, 1'b1, 1'b1, 2'd2, 1'b0), 0, '0);
      // address size code 3 behaves as 64 bit
      add_row(mk_req(64'h1_0000_0003, 64'h40, 64'h80, '0, 2'd3, 1'b0, 1'b1, 2'd3, 1'b0), 0, '0);
      // cap boundaries at the reset cap
      add_row(mk_req(rsms_pkg::MASK_ALL, 64'h100, 64'h200, '0, 2'd2, 1'b0, 1'b1, 2'd2, 1'b0),
              0, '0);
      add_row(mk_req(64'd64, 64'h100, 64'h200, '0, 2'd1, 1'b1, 1'b1, rsms_pkg::ASZ_32, 1'b0),
              0, '0);
      add_row(mk_req(64'd65, 64'h100, 64'h200, '0, 2'd0, 1'b0, 1'b1, rsms_pkg::ASZ_16, 1'b0),
              0, '0);
      // trap flag
      add_row(mk_req(64'd10, 64'h30, 64'h60, '0, 2'd0, 1'b0, 1'b1, 2'd2, 1'b1), 0, '0);
      add_row(mk_req(64'd1, 64'h30, 64'h60, '0, 2'd1, 1'b1, 1'b1, 2'd2, 1'b1), 0, '0);
      add_row(mk_req(64'd7, 64'h30, 64'h60, '0, 2'd2, 1'b0, 1'b0, 2'd2, 1'b1), 0, '0);
      // read address wraps at 64 bits
      add_row(mk_req(64'd3, 64'd1, 64'd2, rsms_pkg::MASK_ALL, 2'd0, 1'b0, 1'b1, 2'd2, 1'b0),
              0, '0);
      add_row(mk_req(rsms_pkg::MASK_ALL, rsms_pkg::MASK_ALL, rsms_pkg::MASK_ALL,
                     rsms_pkg::MASK_ALL, 2'd3, 1'b1, 1'b1, 2'd3, 1'b1), 0, '0);
      add_row(mk_req(64'd2, rsms_pkg::MASK_ALL, rsms_pkg::MASK_ALL, rsms_pkg::MASK_ALL, 2'd3,
                     1'b1, 1'b1, 2'd2, 1'b0), 0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_drain();
         write_cap(caps[p]);
         case (p / 2)
            0: begin
               send_idle_pct  = 7;
               recv_stall_pct = 83;
            end
            1: begin
               send_idle_pct  = 83;
               recv_stall_pct = 7;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PHASE; n++) begin
            send_req(rand_req(), 1'b0, '0);
            if ($urandom_range(0, 29) == 0) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("tb_rep_string_move_sequencer OK");
      else
         $display("tb_rep_string_move_sequencer NOT OK");
      $finish;
   end

endmodule
